// ===== src/aubd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// aubd_pkg: shared types and constants of the access-unit boundary detector
// Holds NAL unit type codes and the structs passed between the parser and
// the front end and top level.
// ============================================================================
package aubd_pkg;

	localparam logic [4:0] NAL_SLICE_MIN = 5'd1;
	localparam logic [4:0] NAL_IDR       = 5'd5;
	localparam logic [4:0] NAL_SPS       = 5'd7;
	localparam logic [4:0] NAL_PPS       = 5'd8;

	localparam logic [7:0] EMU_BYTE      = 8'h03;

	// Result of one NAL unit.
	typedef struct packed {
		logic [4:0]  unit_type;
		logic [1:0]  ref_priority;
		logic        starts_frame;
		logic        closed_frame_key;
		logic        is_slice;
		logic [15:0] picture_width;
		logic [15:0] picture_height;
	} aubd_result_t;

	// Parser hands a payload bank back to the front end.
	typedef struct packed {
		logic vld;
		logic bank;
	} aubd_release_t;

endpackage : aubd_pkg
`default_nettype wire

// ===== src/aubd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// aubd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module aubd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : aubd_ram
`default_nettype wire

// ===== src/aubd_jobq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// aubd_jobq: two-entry job queue
// Carries finished units from the front end to the parser.
// ============================================================================
module aubd_jobq #(
	parameter int W = 20
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire [W-1:0]  push_data,
	input  wire          pop,
	output logic [W-1:0] head_data,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] entry_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign head_data = entry_q[rptr_q];
	assign empty     = (cnt_q == 2'd0);
	assign full      = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule : aubd_jobq
`default_nettype wire

// ===== src/aubd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// aubd_front: byte intake and emulation-prevention removal
// Writes the kept payload of a unit into one of two banks and posts a job
// at the last byte.
// ============================================================================
module aubd_front #(
	parameter int HEADER_BYTES = 2048
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [7:0]                        data_byte,
	input  wire                              first_byte,
	input  wire                              last_byte,
	output logic                             wr_en,
	output logic [$clog2(HEADER_BYTES):0]    wr_addr,
	output logic [7:0]                       wr_data,
	output logic                             job_push,
	output logic [7:0]                       job_head,
	output logic [$clog2(HEADER_BYTES)-1:0]  job_len,
	output logic                             job_bank,
	input  aubd_pkg::aubd_release_t          release_bank
);

	localparam int LW = $clog2(HEADER_BYTES);
	localparam int PW = $clog2(HEADER_BYTES + 1);

	logic          open_q;
	logic          wbank_q;
	logic [1:0]    busy_q;
	logic [PW-1:0] pos_q;
	logic [LW-1:0] len_q;
	logic [1:0]    zrun_q;
	logic [7:0]    head_q;

	logic          take;
	logic          keep_room;
	logic          is_emu;
	logic          store;
	logic [LW-1:0] len_next;

	assign in_ready  = !busy_q[wbank_q];
	assign take      = in_valid && in_ready;
	assign keep_room = (pos_q < PW'(HEADER_BYTES));
	assign is_emu    = (data_byte == aubd_pkg::EMU_BYTE) && (zrun_q == 2'd2);
	assign store     = take && !first_byte && open_q && keep_room && !is_emu;
	assign len_next  = store ? len_q + LW'(1) : len_q;

	assign wr_en    = store;
	assign wr_addr  = {wbank_q, len_q};
	assign wr_data  = data_byte;

	assign job_push = take && last_byte && (first_byte || open_q);
	assign job_head = first_byte ? data_byte : head_q;
	assign job_len  = first_byte ? '0 : len_next;
	assign job_bank = wbank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			wbank_q <= 1'b0;
			busy_q  <= 2'b00;
			pos_q   <= '0;
			len_q   <= '0;
			zrun_q  <= 2'd0;
			head_q  <= 8'd0;
		end else begin
			if (release_bank.vld) begin
				busy_q[release_bank.bank] <= 1'b0;
			end
			if (take) begin
				if (first_byte) begin
					head_q <= data_byte;
					len_q  <= '0;
					zrun_q <= 2'd0;
					pos_q  <= PW'(1);
					open_q <= 1'b1;
				end else if (open_q && keep_room) begin
					pos_q <= pos_q + PW'(1);
					len_q <= len_next;
					if (is_emu) begin
						zrun_q <= 2'd0;
					end else if (data_byte == 8'd0) begin
						zrun_q <= (zrun_q == 2'd2) ? 2'd2 : zrun_q + 2'd1;
					end else begin
						zrun_q <= 2'd0;
					end
				end
				if (job_push) begin
					open_q          <= 1'b0;
					wbank_q         <= ~wbank_q;
					busy_q[wbank_q] <= 1'b1;
				end
			end
		end
	end

endmodule : aubd_front
`default_nettype wire

// ===== src/aubd_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// aubd_parse: bit-serial header parser and frame-boundary decision
// Reads the payload of one unit a bit at a time, decodes Exp-Golomb and
// fixed fields of SPS and slice headers, and registers one result.
// ============================================================================
module aubd_parse #(
	parameter int HEADER_BYTES = 2048
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              job_vld,
	input  wire [7:0]                        job_head,
	input  wire [$clog2(HEADER_BYTES)-1:0]   job_len,
	input  wire                              job_bank,
	output logic                             job_pop,
	output logic [$clog2(HEADER_BYTES):0]    rd_addr,
	input  wire [7:0]                        rd_data,
	output aubd_pkg::aubd_release_t          release_bank,
	output logic                             out_valid,
	input  wire                              out_ready,
	output aubd_pkg::aubd_result_t           result
);

	localparam int LW = $clog2(HEADER_BYTES);

	typedef enum logic [5:0] {
		S_IDLE, S_PROFILE, S_CONSTR, S_SPSID, S_CHROMA, S_BDL, S_BDC, S_BYPASS,
		S_SMFLAG, S_SLFLAG, S_SLDELTA, S_LOG2FN, S_POCTYPE, S_LOG2POC, S_P1FLAG,
		S_P1OFF1, S_P1OFF2, S_P1CYC, S_P1LOOP, S_NREF, S_GAPS, S_WID, S_HGT,
		S_MBSONLY, S_MBAFF, S_D8, S_CROPF, S_CL, S_CR, S_CT, S_CB, S_SPSEND,
		S_FMB, S_STYPE, S_PPSID, S_FN, S_IDR, S_POC, S_FINISH
	} state_t;

	state_t st_q;

	// Current job.
	logic [7:0]    head_q;
	logic [LW-1:0] len_q;
	logic          bank_q;
	logic          start_q;
	logic          oldkey_q;

	// Bit source.
	logic [LW-1:0] bidx_q;
	logic [2:0]    bitpos_q;
	logic [7:0]    byte_q;
	logic          bvld_q;
	logic          rdpend_q;

	// Field reader.
	logic          rd_act_q;
	logic          rd_pre_q;
	logic          rd_ue_q;
	logic [5:0]    rd_cnt_q;
	logic [32:0]   rd_acc_q;
	logic          rd_done_q;
	logic [32:0]   rd_val_q;

	// Persistent stream state.
	logic          pend_q;
	logic          key_q;
	logic [4:0]    prevtype_q;
	logic          prevv_q;
	logic [15:0]   fn_q;
	logic          fnv_q;
	logic [15:0]   idr_q;
	logic          idrv_q;
	logic [15:0]   poc_q;
	logic          pocv_q;
	logic [4:0]    fnbits_q;
	logic [1:0]    pocmode_q;
	logic [4:0]    pocw_q;
	logic [15:0]   wst_q;
	logic [15:0]   hst_q;

	// SPS scratch.
	logic                prof_hi_q;
	logic [2:0]          sl_i_q;
	logic [5:0]          sl_j_q;
	logic [7:0]          sl_last_q;
	logic [8:0]          cyc_q;
	logic signed [39:0]  w_q;
	logic signed [39:0]  h_q;

	logic          out_vld_q;
	aubd_pkg::aubd_result_t res_q;

	logic          past_end;
	logic          bit_ok;
	logic          bit_v;
	logic          take;
	logic          job_start;
	logic          need_rd;
	logic          rd_start;
	logic          op_ue;
	logic [4:0]    op_n;
	logic [32:0]   acc_sh;
	logic [32:0]   acc_fin;
	logic [4:0]    cur_type;
	logic          cur_slice;
	logic          out_free;
	logic [7:0]    se8;
	logic [7:0]    sl_next;
	logic          sl_end;
	logic [15:0]   idr_v;

	function automatic logic [15:0] clamp16(input logic signed [39:0] v);
		logic [15:0] r;
		if (v[39]) begin
			r = 16'd0;
		end else if (|v[38:16]) begin
			r = 16'hffff;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	assign cur_type  = head_q[4:0];
	assign cur_slice = (cur_type >= aubd_pkg::NAL_SLICE_MIN) && (cur_type <= aubd_pkg::NAL_IDR);
	assign out_free  = !out_vld_q || out_ready;

	assign past_end = !(bidx_q < len_q);
	assign bit_ok   = past_end || bvld_q;
	assign bit_v    = !past_end && byte_q[3'd7 - bitpos_q];
	assign take     = rd_act_q && bit_ok;
	assign rd_addr  = {bank_q, bidx_q};

	assign job_start = (st_q == S_IDLE) && job_vld;
	assign job_pop   = job_start;

	assign release_bank.vld  = (st_q == S_FINISH) && out_free;
	assign release_bank.bank = bank_q;

	assign need_rd  = (st_q != S_IDLE) && (st_q != S_SPSEND) && (st_q != S_FINISH);
	assign rd_start = need_rd && !rd_act_q && !rd_done_q;

	assign acc_sh  = {rd_acc_q[31:0], bit_v};
	assign acc_fin = rd_ue_q ? acc_sh - 33'd1 : acc_sh;

	// Low byte of a signed Exp-Golomb value.
	assign se8     = rd_val_q[0] ? rd_val_q[8:1] + 8'd1 : 8'd0 - rd_val_q[8:1];
	assign sl_next = sl_last_q + se8;
	assign sl_end  = (sl_next == 8'd0) ||
		(sl_j_q == ((sl_i_q < 3'd6) ? 6'd15 : 6'd63));
	assign idr_v   = (rd_val_q > 33'd65535) ? 16'hffff : rd_val_q[15:0];

	always_comb begin
		op_ue = 1'b1;
		op_n  = 5'd0;
		case (st_q)
			S_PROFILE: begin
				op_ue = 1'b0;
				op_n  = 5'd8;
			end
			S_CONSTR: begin
				op_ue = 1'b0;
				op_n  = 5'd16;
			end
			S_BYPASS, S_SMFLAG, S_SLFLAG, S_P1FLAG, S_GAPS, S_MBSONLY, S_MBAFF,
			S_D8, S_CROPF: begin
				op_ue = 1'b0;
				op_n  = 5'd1;
			end
			S_FN: begin
				op_ue = 1'b0;
				op_n  = fnbits_q;
			end
			S_POC: begin
				op_ue = 1'b0;
				op_n  = pocw_q;
			end
			default: begin
				op_ue = 1'b1;
				op_n  = 5'd0;
			end
		endcase
	end

	// Bit source: one payload byte at a time from the bank RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bidx_q   <= '0;
			bitpos_q <= 3'd0;
			bvld_q   <= 1'b0;
			rdpend_q <= 1'b0;
			byte_q   <= 8'd0;
		end else if (job_start) begin
			bidx_q   <= '0;
			bitpos_q <= 3'd0;
			bvld_q   <= 1'b0;
			rdpend_q <= 1'b0;
		end else begin
			if (rdpend_q) begin
				byte_q   <= rd_data;
				bvld_q   <= 1'b1;
				rdpend_q <= 1'b0;
			end else if (!bvld_q && !past_end) begin
				rdpend_q <= 1'b1;
			end
			if (take && !past_end) begin
				bitpos_q <= bitpos_q + 3'd1;
				if (bitpos_q == 3'd7) begin
					bvld_q <= 1'b0;
					bidx_q <= bidx_q + LW'(1);
				end
			end
		end
	end

	// Field reader: fixed-width and unsigned Exp-Golomb reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q  <= 1'b0;
			rd_pre_q  <= 1'b0;
			rd_ue_q   <= 1'b0;
			rd_cnt_q  <= 6'd0;
			rd_acc_q  <= 33'd0;
			rd_done_q <= 1'b0;
			rd_val_q  <= 33'd0;
		end else begin
			rd_done_q <= 1'b0;
			if (rd_start) begin
				rd_ue_q <= op_ue;
				if (op_ue) begin
					rd_act_q <= 1'b1;
					rd_pre_q <= 1'b1;
					rd_cnt_q <= 6'd0;
				end else if (op_n == 5'd0) begin
					rd_done_q <= 1'b1;
					rd_val_q  <= 33'd0;
				end else begin
					rd_act_q <= 1'b1;
					rd_pre_q <= 1'b0;
					rd_cnt_q <= {1'b0, op_n};
					rd_acc_q <= 33'd0;
				end
			end else if (take) begin
				if (rd_pre_q) begin
					if (bit_v) begin
						if (rd_cnt_q == 6'd0) begin
							rd_act_q  <= 1'b0;
							rd_done_q <= 1'b1;
							rd_val_q  <= 33'd0;
						end else begin
							rd_pre_q <= 1'b0;
							rd_acc_q <= 33'd1;
						end
					end else if (rd_cnt_q == 6'd31) begin
						// Prefix capped at 32 zeros: suffix follows directly.
						rd_cnt_q <= 6'd32;
						rd_pre_q <= 1'b0;
						rd_acc_q <= 33'd1;
					end else begin
						rd_cnt_q <= rd_cnt_q + 6'd1;
					end
				end else begin
					rd_acc_q <= acc_sh;
					rd_cnt_q <= rd_cnt_q - 6'd1;
					if (rd_cnt_q == 6'd1) begin
						rd_act_q  <= 1'b0;
						rd_done_q <= 1'b1;
						rd_val_q  <= acc_fin;
					end
				end
			end
		end
	end

	// Syntax sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			head_q     <= 8'd0;
			len_q      <= '0;
			bank_q     <= 1'b0;
			start_q    <= 1'b0;
			oldkey_q   <= 1'b0;
			pend_q     <= 1'b0;
			key_q      <= 1'b0;
			prevtype_q <= 5'd0;
			prevv_q    <= 1'b0;
			fn_q       <= 16'd0;
			fnv_q      <= 1'b0;
			idr_q      <= 16'd0;
			idrv_q     <= 1'b0;
			poc_q      <= 16'd0;
			pocv_q     <= 1'b0;
			fnbits_q   <= 5'd0;
			pocmode_q  <= 2'd3;
			pocw_q     <= 5'd0;
			wst_q      <= 16'd0;
			hst_q      <= 16'd0;
			prof_hi_q  <= 1'b0;
			sl_i_q     <= 3'd0;
			sl_j_q     <= 6'd0;
			sl_last_q  <= 8'd0;
			cyc_q      <= 9'd0;
			w_q        <= '0;
			h_q        <= '0;
			out_vld_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (job_vld) begin
						head_q   <= job_head;
						len_q    <= job_len;
						bank_q   <= job_bank;
						oldkey_q <= key_q;
						start_q  <= (job_head[4:0] == aubd_pkg::NAL_SPS) ||
							(job_head[4:0] == aubd_pkg::NAL_PPS);
						if (job_head[4:0] == aubd_pkg::NAL_SPS) begin
							st_q <= S_PROFILE;
						end else if (job_head[4:0] >= aubd_pkg::NAL_SLICE_MIN &&
							job_head[4:0] <= aubd_pkg::NAL_IDR) begin
							st_q <= S_FMB;
						end else begin
							st_q <= S_FINISH;
						end
					end
				end
				S_SPSEND: begin
					wst_q <= clamp16(w_q);
					hst_q <= clamp16(h_q);
					st_q  <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_vld_q              <= 1'b1;
						res_q.unit_type        <= cur_type;
						res_q.ref_priority     <= head_q[6:5];
						res_q.starts_frame     <= start_q && pend_q;
						res_q.closed_frame_key <= start_q && pend_q && oldkey_q;
						res_q.is_slice         <= cur_slice;
						res_q.picture_width    <= wst_q;
						res_q.picture_height   <= hst_q;
						if (cur_slice) begin
							pend_q <= 1'b1;
						end else if (start_q) begin
							pend_q <= 1'b0;
						end
						prevtype_q <= cur_type;
						prevv_q    <= 1'b1;
						st_q       <= S_IDLE;
					end
				end
				default: begin
					if (rd_done_q) begin
						case (st_q)
							S_PROFILE: begin
								prof_hi_q <= (rd_val_q[7:0] >= 8'd100);
								st_q      <= S_CONSTR;
							end
							S_CONSTR:  st_q <= S_SPSID;
							S_SPSID:   st_q <= prof_hi_q ? S_CHROMA : S_LOG2FN;
							S_CHROMA:  st_q <= S_BDL;
							S_BDL:     st_q <= S_BDC;
							S_BDC:     st_q <= S_BYPASS;
							S_BYPASS:  st_q <= S_SMFLAG;
							S_SMFLAG: begin
								sl_i_q <= 3'd0;
								st_q   <= rd_val_q[0] ? S_SLFLAG : S_LOG2FN;
							end
							S_SLFLAG: begin
								if (rd_val_q[0]) begin
									sl_last_q <= 8'd8;
									sl_j_q    <= 6'd0;
									st_q      <= S_SLDELTA;
								end else if (sl_i_q == 3'd7) begin
									st_q <= S_LOG2FN;
								end else begin
									sl_i_q <= sl_i_q + 3'd1;
								end
							end
							S_SLDELTA: begin
								sl_last_q <= sl_next;
								if (sl_end) begin
									if (sl_i_q == 3'd7) begin
										st_q <= S_LOG2FN;
									end else begin
										sl_i_q <= sl_i_q + 3'd1;
										st_q   <= S_SLFLAG;
									end
								end else begin
									sl_j_q <= sl_j_q + 6'd1;
								end
							end
							S_LOG2FN: begin
								fnbits_q <= (rd_val_q > 33'd12) ? 5'd16 :
									{1'b0, rd_val_q[3:0]} + 5'd4;
								st_q <= S_POCTYPE;
							end
							S_POCTYPE: begin
								pocmode_q <= (rd_val_q > 33'd2) ? 2'd2 : rd_val_q[1:0];
								if (rd_val_q == 33'd0) begin
									st_q <= S_LOG2POC;
								end else if (rd_val_q == 33'd1) begin
									st_q <= S_P1FLAG;
								end else begin
									st_q <= S_NREF;
								end
							end
							S_LOG2POC: begin
								pocw_q <= (rd_val_q > 33'd12) ? 5'd16 :
									{1'b0, rd_val_q[3:0]} + 5'd4;
								st_q <= S_NREF;
							end
							S_P1FLAG:  st_q <= S_P1OFF1;
							S_P1OFF1:  st_q <= S_P1OFF2;
							S_P1OFF2:  st_q <= S_P1CYC;
							S_P1CYC: begin
								cyc_q <= (rd_val_q > 33'd256) ? 9'd256 : rd_val_q[8:0];
								st_q  <= (rd_val_q == 33'd0) ? S_NREF : S_P1LOOP;
							end
							S_P1LOOP: begin
								cyc_q <= cyc_q - 9'd1;
								if (cyc_q == 9'd1) begin
									st_q <= S_NREF;
								end
							end
							S_NREF:    st_q <= S_GAPS;
							S_GAPS:    st_q <= S_WID;
							S_WID: begin
								w_q  <= $signed(({7'd0, rd_val_q} + 40'd1) << 4);
								st_q <= S_HGT;
							end
							S_HGT: begin
								h_q  <= $signed(({7'd0, rd_val_q} + 40'd1) << 4);
								st_q <= S_MBSONLY;
							end
							S_MBSONLY: st_q <= rd_val_q[0] ? S_D8 : S_MBAFF;
							S_MBAFF:   st_q <= S_D8;
							S_D8:      st_q <= S_CROPF;
							S_CROPF:   st_q <= rd_val_q[0] ? S_CL : S_SPSEND;
							S_CL: begin
								w_q  <= w_q - $signed({6'd0, rd_val_q, 1'b0});
								st_q <= S_CR;
							end
							S_CR: begin
								w_q  <= w_q - $signed({6'd0, rd_val_q, 1'b0});
								st_q <= S_CT;
							end
							S_CT: begin
								h_q  <= h_q - $signed({6'd0, rd_val_q, 1'b0});
								st_q <= S_CB;
							end
							S_CB: begin
								h_q  <= h_q - $signed({6'd0, rd_val_q, 1'b0});
								st_q <= S_SPSEND;
							end
							S_FMB:     st_q <= S_STYPE;
							S_STYPE: begin
								if (rd_val_q inside {33'd0, 33'd1, 33'd3, 33'd5, 33'd6,
									33'd8}) begin
									key_q <= 1'b0;
								end else if (rd_val_q inside {33'd2, 33'd4, 33'd7,
									33'd9}) begin
									key_q <= (cur_type == aubd_pkg::NAL_IDR);
								end
								st_q <= S_PPSID;
							end
							S_PPSID:   st_q <= S_FN;
							S_FN: begin
								if (!fnv_q || rd_val_q[15:0] != fn_q) begin
									start_q <= 1'b1;
								end
								fn_q  <= rd_val_q[15:0];
								fnv_q <= 1'b1;
								if (cur_type == aubd_pkg::NAL_IDR) begin
									st_q <= S_IDR;
								end else begin
									st_q <= (pocmode_q == 2'd0) ? S_POC : S_FINISH;
								end
							end
							S_IDR: begin
								if (prevv_q && prevtype_q == aubd_pkg::NAL_IDR &&
									(!idrv_q || idr_q != idr_v)) begin
									start_q <= 1'b1;
								end
								idr_q  <= idr_v;
								idrv_q <= 1'b1;
								st_q   <= (pocmode_q == 2'd0) ? S_POC : S_FINISH;
							end
							S_POC: begin
								if (!pocv_q || rd_val_q[15:0] != poc_q) begin
									start_q <= 1'b1;
								end
								poc_q  <= rd_val_q[15:0];
								pocv_q <= 1'b1;
								st_q   <= S_FINISH;
							end
							default: st_q <= S_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign result    = res_q;

endmodule : aubd_parse
`default_nettype wire

// ===== src/h264_access_unit_boundary_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte item per cycle is taken while a payload bank is free;
// two banks let one unit stream in while the previous one is parsed.
// Parse of a unit: each payload byte read is a RAM fetch followed by 8 bit
// steps, and each header field is a field-reader read followed by a sequencer
// step; the result is then registered. Reset is asynchronous and clears all control
// state; payload RAM contents are never cleared and need no clearing pass.
// ============================================================================
// h264_access_unit_boundary_detector: H.264 access-unit boundary detector
// Strips emulation-prevention bytes, parses SPS and slice headers and reports
// per NAL unit whether it opens a new frame.
// ============================================================================
module h264_access_unit_boundary_detector #(
	parameter int HEADER_BYTES = 2048
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         first_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [4:0]  unit_type,
	output logic [1:0]  ref_priority,
	output logic        starts_frame,
	output logic        closed_frame_key,
	output logic        is_slice,
	output logic [15:0] picture_width,
	output logic [15:0] picture_height
);

	// Each payload bank holds one unit's kept bytes; the bank index is the
	// top address bit of the shared RAM.
	localparam int LW = $clog2(HEADER_BYTES);
	localparam int AW = LW + 1;
	localparam int JW = 8 + LW + 1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	logic          push;
	logic [7:0]    push_head;
	logic [LW-1:0] push_len;
	logic          push_bank;
	logic          pop;
	logic [JW-1:0] q_head;
	logic          q_empty;
	logic          q_full;

	aubd_pkg::aubd_release_t rel;
	aubd_pkg::aubd_result_t  res;

	// Front end: byte intake, escape removal, payload write, job post.
	aubd_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.job_push    (push),
		.job_head    (push_head),
		.job_len     (push_len),
		.job_bank    (push_bank),
		.release_bank(rel)
	);

	// Two payload banks in one RAM.
	aubd_ram #(
		.WIDTH(8),
		.DEPTH(2 ** AW)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Short queue of finished units between the two sides.
	aubd_jobq #(
		.W(JW)
	) u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_head, push_len, push_bank}),
		.pop      (pop),
		.head_data(q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Back end: bit-serial header parse, boundary decision, result register.
	aubd_parse #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_vld     (!q_empty),
		.job_head    (q_head[JW-1 -: 8]),
		.job_len     (q_head[LW:1]),
		.job_bank    (q_head[0]),
		.job_pop     (pop),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.release_bank(rel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (res)
	);

	assign unit_type        = res.unit_type;
	assign ref_priority     = res.ref_priority;
	assign starts_frame     = res.starts_frame;
	assign closed_frame_key = res.closed_frame_key;
	assign is_slice         = res.is_slice;
	assign picture_width    = res.picture_width;
	assign picture_height   = res.picture_height;

	// Bank ownership must keep the job queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_full || pop))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job queue underflow");

	a_key_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!closed_frame_key || starts_frame))
		else $error("key flag reported without a closed frame");

	a_slice_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_slice == (unit_type >= 5'd1 && unit_type <= 5'd5)))
		else $error("slice flag disagrees with unit type");

endmodule : h264_access_unit_boundary_detector
`default_nettype wire
